[rtl/tst_pkg.sv]
package tst_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAX_TEX_DIM = 256;
   localparam int MAX_SPAN    = 64;
   localparam int DIM_W       = 9;                     // size field width
   localparam int IDX_W       = $clog2(MAX_TEX_DIM);   // texel index width
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int REM_W       = DIM_W + FRAC_BITS + 2; // holds 2W<<FRAC plus one shift
   localparam int DIGIT_W     = 4;                     // dividend bits retired per cycle
   localparam int MOD_STEPS   = 32 / DIGIT_W;
   localparam int CNT_W       = 7;

   localparam logic [1:0] TILE_CLAMP  = 2'd0;
   localparam logic [1:0] TILE_REPEAT = 2'd1;
   localparam logic [1:0] TILE_MIRROR = 2'd2;

   localparam logic [2:0] REG_MAT_A     = 3'd0;
   localparam logic [2:0] REG_MAT_B     = 3'd1;
   localparam logic [2:0] REG_MAT_C     = 3'd2;
   localparam logic [2:0] REG_MAT_D     = 3'd3;
   localparam logic [2:0] REG_MAT_E     = 3'd4;
   localparam logic [2:0] REG_MAT_F     = 3'd5;
   localparam logic [2:0] REG_TEX_DIMS  = 3'd6;
   localparam logic [2:0] REG_TILE_MODE = 3'd7;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SPAN  = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_SUM  = 6'b000100,
      ST_MOD  = 6'b001000,
      ST_RD   = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // size field: 0 -> 1, above max -> max
   function automatic logic [DIM_W-1:0] fix_size(input logic [DIM_W-1:0] s);
      logic [DIM_W-1:0] r;
      if (s == '0) r = DIM_W'(1);
      else if (s > DIM_W'(MAX_TEX_DIM)) r = DIM_W'(MAX_TEX_DIM);
      else r = s;
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // one radix-16 restoring remainder digit
   function automatic logic [REM_W-1:0] mod_digit(input logic [REM_W-1:0] rem,
                                                  input logic [DIGIT_W-1:0] bits,
                                                  input logic [REM_W-1:0] m);
      logic [REM_W-1:0] r;
      r = rem;
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         r = {r[REM_W-2:0], bits[i]};
         if (r >= m) r = r - m;
      end
      return r;
   endfunction

   function automatic logic [REM_W-1:0] tile_modulus(input logic [DIM_W-1:0] w,
                                                     input logic [1:0] mode);
      logic [REM_W-1:0] one_w;
      one_w = REM_W'(w) << FRAC_BITS;
      return (mode == TILE_MIRROR) ? (one_w << 1) : one_w;
   endfunction

   // texel index from coordinate p, |p| mod M in rem, size w
   function automatic logic [IDX_W-1:0] tile_index(input logic signed [31:0] p,
                                                   input logic [REM_W-1:0] rem,
                                                   input logic [DIM_W-1:0] w,
                                                   input logic [1:0] mode);
      logic [REM_W-1:0]         one_w;
      logic [REM_W-1:0]         m;
      logic [REM_W-1:0]         t;
      logic [REM_W-1:0]         u;
      logic [REM_W-1:0]         lim;
      logic [REM_W-1:0]         n;
      logic [IDX_W-1:0]         r;
      one_w = REM_W'(w) << FRAC_BITS;
      m     = tile_modulus(w, mode);
      t     = (p[31] && rem != '0) ? m - rem : rem;
      lim   = REM_W'(w) - REM_W'(1);
      case (mode)
         TILE_REPEAT: begin
            r = IDX_W'(t >> FRAC_BITS);
         end
         TILE_MIRROR: begin
            u = (t < one_w) ? t : (m - t);
            n = u >> FRAC_BITS;
            r = IDX_W'((n > lim) ? lim : n);
         end
         default: begin
            n = REM_W'(p[30:FRAC_BITS]);
            if (p[31]) r = '0;
            else r = IDX_W'((n > lim) ? lim : n);
         end
      endcase
      return r;
   endfunction

endpackage

[rtl/texture_sampler_tiled_top.sv]
// Nearest-texel sampler. A word with req_operation 0 stores one texel in a
// 256x256 word RAM; busy stays low. A span word maps each pixel center
// through the 16.16 inverse matrix, tiles it (clamp, repeat, mirror) and
// puts out one texel per pixel on rsp_valid, rsp_last marking the final
// one; span_count 0 gives nothing, above 64 is cut to 64. Results cannot be
// held off. A span first runs the setup steps multiply and add/saturate,
// then for each pixel the radix-16 floor-modulo unit that tiles x and y,
// a RAM read and an output step; busy stays high until the last pixel is
// out. Config may only be written while busy is low.
module texture_sampler_tiled_top
   import tst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [11:0] req_span_x,
   input  logic [11:0] req_span_y,
   input  logic [6:0]  req_span_count,
   input  logic [7:0]  req_texel_col,
   input  logic [7:0]  req_texel_row,
   input  logic [31:0] req_texel_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_pixel,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // config registers
   logic signed [31:0] mat_a_ff, mat_b_ff, mat_c_ff, mat_d_ff, mat_e_ff, mat_f_ff;
   logic [2*DIM_W-1:0] tex_dims_ff;
   logic [1:0]         tile_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_a_ff     <= 32'sd65536;
         mat_b_ff     <= '0;
         mat_c_ff     <= '0;
         mat_d_ff     <= '0;
         mat_e_ff     <= 32'sd65536;
         mat_f_ff     <= '0;
         tex_dims_ff  <= 18'd131328;
         tile_mode_ff <= TILE_CLAMP;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MAT_A:     mat_a_ff     <= csr_data;
            REG_MAT_B:     mat_b_ff     <= csr_data;
            REG_MAT_C:     mat_c_ff     <= csr_data;
            REG_MAT_D:     mat_d_ff     <= csr_data;
            REG_MAT_E:     mat_e_ff     <= csr_data;
            REG_MAT_F:     mat_f_ff     <= csr_data;
            REG_TEX_DIMS:  tex_dims_ff  <= csr_data[2*DIM_W-1:0];
            REG_TILE_MODE: tile_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] w_size, h_size;
   logic [REM_W-1:0] m_x, m_y;
   assign w_size = fix_size(tex_dims_ff[DIM_W-1:0]);
   assign h_size = fix_size(tex_dims_ff[2*DIM_W-1:DIM_W]);
   assign m_x    = tile_modulus(w_size, tile_mode_ff);
   assign m_y    = tile_modulus(h_size, tile_mode_ff);

   // sequencer state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [2:0]         iter_ff, iter_in;
   logic [12:0]        x2_ff, y2_ff;            // 2*coord+1
   logic signed [45:0] p_ax_ff, p_by_ff, p_dx_ff, p_ey_ff;
   logic signed [31:0] pt_x_ff, pt_y_ff, pt_x_in, pt_y_in;
   logic [31:0]        div_x_ff, div_y_ff;      // |point| shifted out a digit at a time
   logic [REM_W-1:0]   rem_x_ff, rem_y_ff;
   logic               load_mod;

   logic accept;
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   logic [CNT_W-1:0] count_cut;
   assign count_cut = (req_span_count > CNT_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : req_span_count;

   logic signed [46:0] sum_x, sum_y;
   assign sum_x = 47'(p_ax_ff) + 47'(p_by_ff);
   assign sum_y = 47'(p_dx_ff) + 47'(p_ey_ff);

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      iter_in  = iter_ff;
      pt_x_in  = pt_x_ff;
      pt_y_in  = pt_y_ff;
      load_mod = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_operation == OP_SPAN && count_cut != '0) begin
               state_in = ST_MUL;
               left_in  = count_cut;
            end
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: begin
            pt_x_in  = sat32(48'(sum_x >>> 1) + 48'(mat_c_ff));
            pt_y_in  = sat32(48'(sum_y >>> 1) + 48'(mat_f_ff));
            load_mod = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            iter_in = iter_ff + 3'd1;
            if (iter_ff == 3'(MOD_STEPS - 1)) state_in = ST_RD;
         end
         ST_RD: state_in = ST_OUT;
         ST_OUT: begin
            pt_x_in = sat32(48'(pt_x_ff) + 48'(mat_a_ff));
            pt_y_in = sat32(48'(pt_y_ff) + 48'(mat_d_ff));
            left_in = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end else begin
               load_mod = 1'b1;
               state_in = ST_MOD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
         iter_ff  <= '0;
         pt_x_ff  <= '0;
         pt_y_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         iter_ff  <= load_mod ? 3'd0 : iter_in;
         pt_x_ff  <= pt_x_in;
         pt_y_ff  <= pt_y_in;
      end
   end

   // setup datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         x2_ff <= {req_span_x, 1'b1};
         y2_ff <= {req_span_y, 1'b1};
      end
      p_ax_ff <= mat_a_ff * $signed({1'b0, x2_ff});
      p_by_ff <= mat_b_ff * $signed({1'b0, y2_ff});
      p_dx_ff <= mat_d_ff * $signed({1'b0, x2_ff});
      p_ey_ff <= mat_e_ff * $signed({1'b0, y2_ff});
   end

   // floor-modulo unit, x and y side by side
   always_ff @(posedge clock) begin
      if (load_mod) begin
         div_x_ff <= pt_x_in[31] ? 32'(-pt_x_in) : 32'(pt_x_in);
         div_y_ff <= pt_y_in[31] ? 32'(-pt_y_in) : 32'(pt_y_in);
         rem_x_ff <= '0;
         rem_y_ff <= '0;
      end else if (state_ff == ST_MOD) begin
         div_x_ff <= div_x_ff << DIGIT_W;
         div_y_ff <= div_y_ff << DIGIT_W;
         rem_x_ff <= mod_digit(rem_x_ff, div_x_ff[31 -: DIGIT_W], m_x);
         rem_y_ff <= mod_digit(rem_y_ff, div_y_ff[31 -: DIGIT_W], m_y);
      end
   end

   // texture RAM: one write port, one registered read port
   logic [31:0]       tex_mem [0:(1 << ADDR_W) - 1];
   logic [31:0]       rd_data_ff;
   logic [IDX_W-1:0]  tx, ty;
   logic              tex_wr;

   assign tx     = tile_index(pt_x_ff, rem_x_ff, w_size, tile_mode_ff);
   assign ty     = tile_index(pt_y_ff, rem_y_ff, h_size, tile_mode_ff);
   assign tex_wr = accept && (req_operation == OP_WRITE);

   always_ff @(posedge clock) begin
      if (tex_wr) tex_mem[{req_texel_row, req_texel_col}] <= req_texel_value;
      if (state_ff == ST_RD) rd_data_ff <= tex_mem[{ty, tx}];
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_pixel = rd_data_ff;
   assign rsp_last  = (state_ff == ST_OUT) && (left_ff == CNT_W'(1));

`ifndef NO_ASSERTIONS
   a_last_marks_word: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without a result word");
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_WRITE) |=> !busy)
      else $error("texel write made the block busy");
   a_span_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_SPAN && req_span_count != '0) |=> busy)
      else $error("span not taken");
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result words too close");
`endif

endmodule

[tb/texture_sampler_tiled_top_tb.sv]
`timescale 1ns / 100ps

module texture_sampler_tiled_top_tb;
   import tst_pkg::*;

   // Predicts the texel stream of each span from its own copy of the
   // matrix, sizes, tile mode and texture store, and checks words in order.
   class TexelScoreboard;
      longint      mat[6];
      int unsigned dims;
      int unsigned mode;
      bit [31:0]   store[int];
      int          addr_q[$];
      bit [31:0]   pixel_q[$];
      bit          last_q[$];
      int          errors;

      function new();
         mat = '{longint'(1) << FRAC_BITS, 0, 0, 0, longint'(1) << FRAC_BITS, 0};
         dims = 131328;
         mode = TILE_CLAMP;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, bit [31:0] v);
         if (idx <= REG_MAT_F) mat[idx] = longint'(signed'(v));
         else if (idx == REG_TEX_DIMS) dims = v & 32'h3FFFF;
         else mode = v & 32'h3;
      endfunction

      function longint clip(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint eff_size(int unsigned s);
         if (s == 0) return 1;
         if (s > MAX_TEX_DIM) return MAX_TEX_DIM;
         return s;
      endfunction

      function longint fmod(longint v, longint m);
         longint r;
         r = v % m;
         return (r < 0) ? r + m : r;
      endfunction

      // coordinate to texel index under the current tile mode
      function longint wrap_coord(longint p, longint sz);
         longint n, one, t, idx;
         n = p >>> FRAC_BITS;
         one = longint'(1) << FRAC_BITS;
         if (mode == TILE_REPEAT) return fmod(n, sz);
         if (mode == TILE_MIRROR) begin
            t = fmod(p, 2 * sz * one);
            idx = (t < sz * one) ? (t >>> FRAC_BITS) : ((2 * sz * one - t) >>> FRAC_BITS);
            return (idx > sz - 1) ? sz - 1 : idx;
         end
         if (p < 0) return 0;
         return (n > sz - 1) ? sz - 1 : n;
      endfunction

      // store addresses a span reads, in emit order, left in addr_q
      function void span_addrs(bit [11:0] x, bit [11:0] y, bit [6:0] cnt);
         longint x2, y2, px, py, w, h;
         int c;
         addr_q.delete();
         c = (cnt > MAX_SPAN) ? MAX_SPAN : cnt;
         x2 = 2 * longint'(x) + 1;
         y2 = 2 * longint'(y) + 1;
         px = clip(((mat[0] * x2 + mat[1] * y2) >>> 1) + mat[2]);
         py = clip(((mat[3] * x2 + mat[4] * y2) >>> 1) + mat[5]);
         w = eff_size(dims & 9'h1FF);
         h = eff_size((dims >> 9) & 9'h1FF);
         for (int k = 0; k < c; k++) begin
            addr_q.push_back(int'(wrap_coord(py, h) * MAX_TEX_DIM + wrap_coord(px, w)));
            px = clip(px + mat[0]);
            py = clip(py + mat[3]);
         end
      endfunction

      function void note_input(logic op, bit [11:0] x, bit [11:0] y, bit [6:0] cnt,
                               bit [7:0] col, bit [7:0] row, bit [31:0] val);
         if (op == OP_WRITE) begin
            store[int'(row) * MAX_TEX_DIM + col] = val;
            return;
         end
         span_addrs(x, y, cnt);
         foreach (addr_q[k]) begin
            pixel_q.push_back(store.exists(addr_q[k]) ? store[addr_q[k]] : 32'h0);
            last_q.push_back(k == addr_q.size() - 1);
         end
      endfunction

      function void check_result(bit [31:0] pixel, bit last);
         bit [31:0] ep;
         bit el;
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected word pixel %h last %b", $time, pixel, last);
            errors++;
            return;
         end
         ep = pixel_q.pop_front();
         el = last_q.pop_front();
         if (pixel !== ep) begin
            $display("%0t: pixel expected %h actual %h", $time, ep, pixel);
            errors++;
         end
         if (last !== el) begin
            $display("%0t: last expected %b actual %b", $time, el, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [11:0] req_span_x;
   logic [11:0] req_span_y;
   logic [6:0]  req_span_count;
   logic [7:0]  req_texel_col;
   logic [7:0]  req_texel_row;
   logic [31:0] req_texel_value;
   logic        rsp_valid;
   logic [31:0] rsp_pixel;
   logic        rsp_last;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   TexelScoreboard sb = new();
   int burst_left = 0;
   int phase_words;

   texture_sampler_tiled_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("texture_sampler_tiled_top test failed");
      $finish;
   end

   // results cannot be held off: take every strobed word
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_pixel, rsp_last);
   end

   // one word on the request port; bursts of back-to-back words with
   // random gaps in between, start kept high across a burst
   task automatic put_word(logic op, bit [11:0] x, bit [11:0] y, bit [6:0] cnt,
                           bit [7:0] col, bit [7:0] row, bit [31:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_operation <= op;
      req_span_x <= x;
      req_span_y <= y;
      req_span_count <= cnt;
      req_texel_col <= col;
      req_texel_row <= row;
      req_texel_value <= val;
      do @(posedge clock); while (busy);
      sb.note_input(op, x, y, cnt, col, row, val);
      phase_words++;
   endtask

   task automatic put_texel(bit [7:0] col, bit [7:0] row, bit [31:0] val);
      put_word(OP_WRITE, $urandom, $urandom, $urandom, col, row, val);
   endtask

   // a span, preceded by writes of any texel it would read unwritten
   task automatic put_span(bit [11:0] x, bit [11:0] y, bit [6:0] cnt);
      int q[$];
      sb.span_addrs(x, y, cnt);
      q = sb.addr_q;
      foreach (q[k]) begin
         if (!sb.store.exists(q[k])) put_texel(q[k] % MAX_TEX_DIM, q[k] / MAX_TEX_DIM, $urandom);
      end
      put_word(OP_SPAN, x, y, cnt, $urandom, $urandom, $urandom);
   endtask

   // sender holds off until every expected word is in and the block is idle
   task automatic drain();
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pixel_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, bit [31:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_write_enable <= 1'b0;
   endtask

   function automatic bit [31:0] rand_term(int mag);
      int v;
      v = $urandom_range(0, mag);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   task automatic set_phase(int ph);
      bit [31:0] w, h;
      drain();
      case (ph % 5)
         0: begin
            w = 0;
            h = 0;
         end
         1: begin
            w = 511;
            h = 511;
         end
         2: begin
            w = 256;
            h = $urandom_range(1, 8);
         end
         default: begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
         end
      endcase
      if (ph == 3) begin
         // saturation in both directions
         write_reg(REG_MAT_A, 32'h7FFF_FFFF);
         write_reg(REG_MAT_B, 32'h8000_0000);
         write_reg(REG_MAT_C, 32'h7FFF_FFFF);
         write_reg(REG_MAT_D, 32'h8000_0000);
         write_reg(REG_MAT_E, 32'h7FFF_FFFF);
         write_reg(REG_MAT_F, 32'h8000_0000);
      end else begin
         write_reg(REG_MAT_A, rand_term(3 << FRAC_BITS));
         write_reg(REG_MAT_B, rand_term(2 << FRAC_BITS));
         write_reg(REG_MAT_C, (ph == 7) ? $urandom : rand_term(400 << FRAC_BITS));
         write_reg(REG_MAT_D, rand_term(2 << FRAC_BITS));
         write_reg(REG_MAT_E, rand_term(3 << FRAC_BITS));
         write_reg(REG_MAT_F, rand_term(400 << FRAC_BITS));
      end
      write_reg(REG_TEX_DIMS, (h << 9) | w);
      write_reg(REG_TILE_MODE, ph % 4);
   endtask

   initial begin
      bit [6:0] cnt;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_WRITE;
      req_span_x = '0;
      req_span_y = '0;
      req_span_count = '0;
      req_texel_col = '0;
      req_texel_row = '0;
      req_texel_value = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_MAT_A;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset config: identity, 256x256, clamp
      put_texel(8'd0, 8'd0, 32'h0000_0000);
      put_texel(8'd255, 8'd255, 32'hFFFF_FFFF);
      put_span(12'd0, 12'd0, 7'd1);
      put_span(12'd4095, 12'd4095, 7'd64);           // clamps to far corner
      put_span(12'd250, 12'd255, 7'd12);
      put_word(OP_SPAN, 12'd5, 12'd5, 7'd0, 8'd0, 8'd0, 32'h0);   // empty span
      put_span(12'd4095, 12'd0, 7'd127);             // long span, cut to 64
      put_span(12'd0, 12'd4095, 7'd65);
      drain();
      write_reg(REG_TILE_MODE, TILE_MIRROR);
      write_reg(REG_MAT_C, 32'hFFF0_0000);            // negative coordinates
      write_reg(REG_TEX_DIMS, (32'd5 << 9) | 32'd7);
      put_span(12'd0, 12'd3, 7'd30);
      drain();
      write_reg(REG_TILE_MODE, TILE_REPEAT);
      put_span(12'd2, 12'd9, 7'd30);

      // random phases, each through a fresh register setting
      for (int ph = 0; ph < 10; ph++) begin
         set_phase(ph);
         phase_words = 0;
         while (phase_words < 18) begin
            case ($urandom_range(0, 15))
               0, 1, 2: put_texel($urandom, $urandom, $urandom);
               3: begin
                  if ($urandom_range(0, 1))
                     put_word(OP_SPAN, $urandom, $urandom, 7'd0,
                              $urandom, $urandom, $urandom);
                  else
                     put_span($urandom, $urandom, 7'($urandom_range(65, 127)));
               end
               4: put_span($urandom, $urandom, 7'd64);
               default: begin
                  cnt = $urandom_range(1, 16);
                  put_span($urandom, $urandom, cnt);
               end
            endcase
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
         $display("texture_sampler_tiled_top test passed");
      end else begin
         $display("texture_sampler_tiled_top test failed");
      end
      $finish;
   end

endmodule
